[hdl/dpc_pkg.sv]
package dpc_pkg;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_CLEAR      = 2'd1,
      OP_LOAD_TOTAL = 2'd2,
      OP_LOAD_PULSE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_SAMPLE   = 2'd1,
      PH_CONFIRM1 = 2'd2,
      PH_CONFIRM2 = 2'd3
   } phase_type;

   localparam logic [2:0] MODE_NONE         = 3'd0;
   localparam logic [2:0] MODE_CHANGE       = 3'd1;
   localparam logic [2:0] MODE_RISING       = 3'd2;
   localparam logic [2:0] MODE_FALLING      = 3'd3;
   localparam logic [2:0] MODE_PULSE_LOW    = 3'd4;
   localparam logic [2:0] MODE_PULSE_HIGH   = 3'd5;
   localparam logic [2:0] MODE_PULSE_CHANGE = 3'd6;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd1;

   typedef struct packed {
      logic [1:0]  operation;
      logic        pin_level;
      logic [31:0] load_count;
      logic [31:0] load_time;
   } req_word_type;

   typedef struct packed {
      logic [31:0] pulse_count;
      logic [31:0] total_count;
      logic [31:0] pulse_time;
      logic        counted;
   } rsp_word_type;

   typedef struct packed {
      logic                      write;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_write_type;

endpackage

[hdl/dpc_core.sv]
module dpc_core import dpc_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          fire,
   input  req_word_type  req,
   output rsp_word_type  rsp
);

   logic [2:0]           mode_ff, mode_in;
   logic [23:0]          db_ff, db_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic                 prev_ff, prev_in;
   phase_type            phase_ff, phase_in;
   logic [TIME_BITS-1:0] deadline_ff, deadline_in;
   logic                 checked_ff, checked_in;
   logic                 stable_ff, stable_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] high_ff, high_in;
   logic [TIME_BITS-1:0] low_ff, low_in;
   logic [31:0]          pcount_ff, pcount_in;
   logic [31:0]          tcount_ff, tcount_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic                 hit;

   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] gap;
   logic [TIME_BITS-1:0] half;
   logic [TIME_BITS-1:0] db_t;
   logic [TIME_BITS-1:0] db_twice;
   logic [TIME_BITS-1:0] change;
   logic [TIME_BITS-1:0] since;
   logic                 due;
   logic                 edge_seen;
   logic                 qualifies;

   assign now      = tick_ff + TIME_BITS'(1);
   assign gap      = now - deadline_ff;
   assign due      = (phase_ff != PH_IDLE) && !gap[TIME_BITS-1];
   assign half     = TIME_BITS'(db_ff[23:1]);
   assign db_t     = TIME_BITS'(db_ff);
   assign db_twice = TIME_BITS'({db_ff, 1'b0});
   assign change   = now - db_twice;
   assign edge_seen = req.pin_level != prev_ff;

   always_comb begin
      mode_in     = mode_ff;
      db_in       = db_ff;
      tick_in     = tick_ff;
      prev_in     = prev_ff;
      phase_in    = phase_ff;
      deadline_in = deadline_ff;
      checked_in  = checked_ff;
      stable_in   = stable_ff;
      start_in    = start_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      pcount_in   = pcount_ff;
      tcount_in   = tcount_ff;
      last_in     = last_ff;
      hit         = 1'b0;
      since       = '0;
      qualifies   = 1'b0;

      unique case (op_type'(req.operation))
         OP_TICK: begin
            tick_in = now;
            if (due) begin
               unique case (phase_ff)
                  PH_SAMPLE: begin
                     checked_in  = req.pin_level;
                     deadline_in = now + half;
                     phase_in    = PH_CONFIRM1;
                  end
                  PH_CONFIRM1: begin
                     if (req.pin_level == checked_ff) begin
                        phase_in = PH_CONFIRM2;
                     end else begin
                        checked_in = req.pin_level;
                     end
                     deadline_in = now + half;
                  end
                  PH_CONFIRM2: begin
                     if (stable_ff) begin
                        high_in = change - start_ff;
                     end else begin
                        low_in = change - start_ff;
                     end
                     if (req.pin_level == checked_ff) begin
                        if (req.pin_level != stable_ff) begin
                           stable_in = req.pin_level;
                           start_in  = change;
                           if (mode_ff == MODE_PULSE_CHANGE) begin
                              last_in   = stable_in ? low_in : high_in;
                              pcount_in = pcount_ff + 32'd1;
                              tcount_in = tcount_ff + 32'd1;
                              hit       = 1'b1;
                           end else if ((mode_ff == MODE_PULSE_HIGH && !stable_in) ||
                                        (mode_ff == MODE_PULSE_LOW && stable_in)) begin
                              last_in   = low_in + high_in;
                              pcount_in = pcount_ff + 32'd1;
                              tcount_in = tcount_ff + 32'd1;
                              hit       = 1'b1;
                           end
                        end
                        phase_in = PH_IDLE;
                     end else begin
                        checked_in  = req.pin_level;
                        phase_in    = PH_CONFIRM1;
                        deadline_in = now + half;
                     end
                  end
                  PH_IDLE: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end

            if (mode_ff == MODE_CHANGE || mode_ff == MODE_RISING ||
                mode_ff == MODE_FALLING) begin
               qualifies = (mode_ff == MODE_CHANGE && edge_seen) ||
                           (mode_ff == MODE_RISING && edge_seen && req.pin_level) ||
                           (mode_ff == MODE_FALLING && edge_seen && !req.pin_level);
               since = now - start_in;
               if (qualifies && (64'(since) > 64'(db_ff))) begin
                  last_in   = since;
                  pcount_in = pcount_in + 32'd1;
                  tcount_in = tcount_in + 32'd1;
                  start_in  = now;
                  hit       = 1'b1;
               end
            end else if (mode_ff == MODE_PULSE_LOW || mode_ff == MODE_PULSE_HIGH ||
                         mode_ff == MODE_PULSE_CHANGE) begin
               if (edge_seen && phase_in == PH_IDLE) begin
                  phase_in    = PH_SAMPLE;
                  deadline_in = now + db_t;
               end
            end
            prev_in = req.pin_level;
         end
         OP_CLEAR: begin
            pcount_in = '0;
            last_in   = '0;
         end
         OP_LOAD_TOTAL: begin
            tcount_in = req.load_count;
         end
         OP_LOAD_PULSE: begin
            pcount_in = req.load_count;
            last_in   = TIME_BITS'(req.load_time);
         end
      endcase

      rsp.pulse_count = pcount_in;
      rsp.total_count = tcount_in;
      rsp.pulse_time  = 32'(64'(last_in));
      rsp.counted     = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NONE;
         db_ff       <= '0;
         tick_ff     <= '0;
         prev_ff     <= 1'b1;
         phase_ff    <= PH_IDLE;
         deadline_ff <= '0;
         checked_ff  <= 1'b1;
         stable_ff   <= 1'b0;
         start_ff    <= '0;
         high_ff     <= '0;
         low_ff      <= '0;
         pcount_ff   <= '0;
         tcount_ff   <= '0;
         last_ff     <= '0;
      end else begin
         if (fire) begin
            tick_ff     <= tick_in;
            prev_ff     <= prev_in;
            phase_ff    <= phase_in;
            deadline_ff <= deadline_in;
            start_ff    <= start_in;
            high_ff     <= high_in;
            low_ff      <= low_in;
            pcount_ff   <= pcount_in;
            tcount_ff   <= tcount_in;
            last_ff     <= last_in;
         end
         if (csr.write && csr.index == CSR_TRIGGER_MODE) begin
            mode_ff    <= csr.data[2:0];
            stable_ff  <= csr.data[2:0] == MODE_PULSE_LOW;
            checked_ff <= 1'b1;
         end else begin
            if (fire) begin
               checked_ff <= checked_in;
               stable_ff  <= stable_in;
            end
            if (csr.write && csr.index == CSR_DEBOUNCE_TICKS) begin
               db_ff <= csr.data;
            end else begin
               db_ff <= db_in;
            end
            mode_ff <= mode_in;
         end
      end
   end

endmodule

[hdl/debounced_pulse_counter_top.sv]
// channel  direction  word            handshake
// req      in         req_word_type   req_valid / req_ready
// rsp      out        rsp_word_type   rsp_valid / rsp_ready
// csr      in         index + data    csr_valid / csr_ready (always ready)
//
// one word per cycle sustained while rsp_ready stays high; each word waits in
// the input register until the result register is free, then moves into it
// the counter state advances as a word moves from input to result register
// synchronous reset clears valid flags; core mode none, counters and time at zero
// a stalled result holds the input register; req_ready drops only when both are full
module debounced_pulse_counter_top import dpc_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_word_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_word_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic          in_valid_ff;
   req_word_type  in_data_ff;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_data_ff;
   rsp_word_type  rsp_next;
   csr_write_type csr;
   logic          advance;

   assign csr_ready = 1'b1;
   assign csr.write = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dpc_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .csr(csr),
      .fire(advance),
      .req(in_data_ff),
      .rsp(rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

`ifndef SYNTH
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input word dropped while result stalled");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff))
      else $error("req_ready low with a free stage");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

[sim/dpc_checker.sv]
`timescale 1ns / 1ps

module dpc_checker import dpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_word_type              req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_word_type              rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        failures,
   output int                        pending,
   output int                        pulses_seen
);

   rsp_word_type expected_counts[$];

   logic [2:0]  mode;
   logic [23:0] debounce;
   logic [31:0] tick_now;
   logic [31:0] deadline;
   logic [31:0] stable_t0;
   logic [31:0] high_dur;
   logic [31:0] low_dur;
   logic [31:0] pulse_cnt;
   logic [31:0] total_cnt;
   logic [31:0] pulse_t;
   logic        prev_pin;
   logic        chk_level;
   logic        stable_lvl;
   phase_type   phase_q;

   function automatic void clear_state();
      mode = MODE_NONE;
      debounce = '0;
      tick_now = '0;
      deadline = '0;
      stable_t0 = '0;
      high_dur = '0;
      low_dur = '0;
      pulse_cnt = '0;
      total_cnt = '0;
      pulse_t = '0;
      prev_pin = 1'b1;
      chk_level = 1'b1;
      stable_lvl = 1'b0;
      phase_q = PH_IDLE;
   endfunction

   function automatic void tally(logic [31:0] t);
      pulse_t = t;
      pulse_cnt = pulse_cnt + 1;
      total_cnt = total_cnt + 1;
   endfunction

   // one phase of the level check, returns 1 when a pulse was counted
   function automatic logic run_check(logic pin);
      logic [31:0] half;
      logic [31:0] change;
      logic        hit;
      half = {9'd0, debounce[23:1]};
      hit = 1'b0;
      case (phase_q)
         PH_SAMPLE: begin
            chk_level = pin;
            deadline = tick_now + half;
            phase_q = PH_CONFIRM1;
         end
         PH_CONFIRM1: begin
            if (pin == chk_level) begin
               phase_q = PH_CONFIRM2;
            end else begin
               chk_level = pin;
            end
            deadline = tick_now + half;
         end
         PH_CONFIRM2: begin
            change = tick_now - {7'd0, debounce, 1'b0};
            if (stable_lvl) begin
               high_dur = change - stable_t0;
            end else begin
               low_dur = change - stable_t0;
            end
            if (pin == chk_level) begin
               if (pin != stable_lvl) begin
                  stable_lvl = pin;
                  stable_t0 = change;
                  if (mode == MODE_PULSE_CHANGE) begin
                     tally(stable_lvl ? low_dur : high_dur);
                     hit = 1'b1;
                  end else if ((mode == MODE_PULSE_HIGH && !stable_lvl) ||
                               (mode == MODE_PULSE_LOW && stable_lvl)) begin
                     tally(low_dur + high_dur);
                     hit = 1'b1;
                  end
               end
               phase_q = PH_IDLE;
            end else begin
               chk_level = pin;
               phase_q = PH_CONFIRM1;
               deadline = tick_now + half;
            end
         end
         default: begin
            phase_q = PH_IDLE;
         end
      endcase
      return hit;
   endfunction

   function automatic rsp_word_type count_word(req_word_type w);
      rsp_word_type r;
      logic         hit;
      logic         edge_seen;
      logic         qual;
      logic [31:0]  since;
      logic [31:0]  diff;
      op_type       op;
      hit = 1'b0;
      op = op_type'(w.operation);
      case (op)
         OP_TICK: begin
            tick_now = tick_now + 1;
            diff = tick_now - deadline;
            if (phase_q != PH_IDLE && !diff[31]) begin
               hit = run_check(w.pin_level);
            end
            edge_seen = (w.pin_level != prev_pin);
            if (mode >= MODE_CHANGE && mode <= MODE_FALLING) begin
               qual = (mode == MODE_CHANGE && edge_seen) ||
                      (mode == MODE_RISING && edge_seen && w.pin_level) ||
                      (mode == MODE_FALLING && edge_seen && !w.pin_level);
               if (qual) begin
                  since = tick_now - stable_t0;
                  if (since > {8'd0, debounce}) begin
                     tally(since);
                     stable_t0 = tick_now;
                     hit = 1'b1;
                  end
               end
            end else if (mode >= MODE_PULSE_LOW && mode <= MODE_PULSE_CHANGE) begin
               if (edge_seen && phase_q == PH_IDLE) begin
                  phase_q = PH_SAMPLE;
                  deadline = tick_now + {8'd0, debounce};
               end
            end
            prev_pin = w.pin_level;
         end
         OP_CLEAR: begin
            pulse_cnt = '0;
            pulse_t = '0;
         end
         OP_LOAD_TOTAL: begin
            total_cnt = w.load_count;
         end
         default: begin
            pulse_cnt = w.load_count;
            pulse_t = w.load_time;
         end
      endcase
      r.pulse_count = pulse_cnt;
      r.total_count = total_cnt;
      r.pulse_time = pulse_t;
      r.counted = hit;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         clear_state();
         expected_counts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TRIGGER_MODE) begin
               mode = csr_data[2:0];
               stable_lvl = (mode == MODE_PULSE_LOW);
               chk_level = 1'b1;
            end else if (csr_index == CSR_DEBOUNCE_TICKS) begin
               debounce = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            expected_counts.push_back(count_word(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               failures++;
               $display("%0t unexpected word: actual %h", $time, rsp_data);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_data.counted) begin
                  pulses_seen++;
               end
               if (rsp_data.pulse_count !== want.pulse_count) begin
                  failures++;
                  $display("%0t pulse_count expected %h actual %h",
                           $time, want.pulse_count, rsp_data.pulse_count);
               end
               if (rsp_data.total_count !== want.total_count) begin
                  failures++;
                  $display("%0t total_count expected %h actual %h",
                           $time, want.total_count, rsp_data.total_count);
               end
               if (rsp_data.pulse_time !== want.pulse_time) begin
                  failures++;
                  $display("%0t pulse_time expected %h actual %h",
                           $time, want.pulse_time, rsp_data.pulse_time);
               end
               if (rsp_data.counted !== want.counted) begin
                  failures++;
                  $display("%0t counted expected %b actual %b",
                           $time, want.counted, rsp_data.counted);
               end
            end
         end
      end
      pending <= expected_counts.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb import dpc_pkg::*; ();

   localparam logic [2:0]                MODE_UNUSED = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED  = 2'd3;
   localparam int                        PHASE_COUNT = 13;
   localparam int                        PHASE_WORDS = 62;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_word_type              req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_word_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int failures;
   int pending;
   int pulses_seen;

   int   words_sent = 0;
   int   tx_quiet = 0;
   int   rx_quiet = 0;
   bit   hold_rx = 1'b0;
   logic run_level = 1'b1;
   int   run_left = 0;

   logic [2:0]  phase_mode[PHASE_COUNT];
   logic [23:0] phase_deb[PHASE_COUNT];

   debounced_pulse_counter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dpc_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending),
      .pulses_seen (pulses_seen)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type make_word(op_type op, logic pin,
                                              logic [31:0] cnt, logic [31:0] load_t);
      req_word_type w;
      w.operation = op;
      w.pin_level = pin;
      w.load_count = cnt;
      w.load_time = load_t;
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      if (tx_quiet > 0) begin
         tx_quiet--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 18);
         if ($urandom_range(0, 19) == 0) begin
            tx_quiet = $urandom_range(20, 60);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [23:0] val, bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (last) begin
         csr_valid <= 1'b0;
      end
   endtask

   task automatic set_mode(logic [2:0] m, logic [23:0] deb);
      drain();
      csr_write(CSR_TRIGGER_MODE, {21'($urandom), m}, 1'b0);
      csr_write(CSR_DEBOUNCE_TICKS, deb, 1'b1);
   endtask

   // mostly stable runs of one level, some glitches and counter operations
   function automatic req_word_type random_word(logic [23:0] deb);
      int span;
      op_type op;
      if ($urandom_range(0, 99) < 8) begin
         op = op_type'($urandom_range(1, 3));
         return make_word(op, 1'($urandom_range(0, 1)), pick32(), pick32());
      end
      if (run_left == 0) begin
         span = (deb > 40) ? 40 : int'(deb);
         run_level = ~run_level;
         if ($urandom_range(0, 99) < 15) begin
            run_left = $urandom_range(1, 2);
         end else begin
            run_left = $urandom_range(1, 3 * span + 6);
         end
      end
      run_left--;
      return make_word(OP_TICK, run_level, pick32(), pick32());
   endfunction

   initial begin : receiver
      int wait_n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rx) begin
            hold_rx = 1'b0;
            wait_n = 80;
         end else if (rx_quiet > 0) begin
            rx_quiet--;
            wait_n = 0;
         end else begin
            wait_n = $urandom_range(0, 18);
            if ($urandom_range(0, 19) == 0) begin
               rx_quiet = $urandom_range(20, 60);
            end
         end
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      phase_mode = '{MODE_CHANGE, MODE_RISING, MODE_FALLING, MODE_PULSE_LOW,
                     MODE_PULSE_HIGH, MODE_PULSE_CHANGE, MODE_PULSE_CHANGE, MODE_NONE,
                     MODE_UNUSED, MODE_CHANGE, MODE_PULSE_LOW, MODE_PULSE_HIGH,
                     MODE_RISING};
      phase_deb = '{24'd3, 24'd0, 24'd5, 24'd2, 24'd4, 24'd0, 24'd7, 24'd1,
                    24'd2, 24'hFF_FFFF, 24'd1, 24'd12, 24'd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // edge counting with no debounce, counter wrap and loads
      csr_write(CSR_UNUSED, 24'($urandom), 1'b0);
      csr_write(CSR_TRIGGER_MODE, {21'd0, MODE_CHANGE}, 1'b0);
      csr_write(CSR_DEBOUNCE_TICKS, 24'd0, 1'b1);
      send_word(make_word(OP_TICK, 1'b0, 32'h0, 32'h0));
      send_word(make_word(OP_TICK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(OP_TICK, 1'b1, 32'h0, 32'h0));
      send_word(make_word(OP_LOAD_TOTAL, 1'b1, 32'hFFFF_FFFF, 32'h0));
      send_word(make_word(OP_TICK, 1'b0, 32'h0, 32'h0));
      send_word(make_word(OP_LOAD_PULSE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(OP_TICK, 1'b1, 32'h0, 32'h0));
      send_word(make_word(OP_CLEAR, 1'b0, pick32(), pick32()));
      send_word(make_word(OP_LOAD_PULSE, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA));
      send_word(make_word(OP_LOAD_TOTAL, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555));
      send_word(make_word(OP_LOAD_PULSE, 1'b0, 32'h0, 32'h0));

      // pulse check with zero debounce
      set_mode(MODE_PULSE_CHANGE, 24'd0);
      for (int i = 0; i < 8; i++) begin
         send_word(make_word(OP_TICK, (i >= 4), 32'h0, 32'h0));
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_mode(phase_mode[p], phase_deb[p]);
         if (p == 2) begin
            hold_rx = 1'b1;
            tx_quiet = 40;
         end
         for (int i = 0; i < PHASE_WORDS; i++) begin
            send_word(random_word(phase_deb[p]));
         end
      end

      drain();
      $display("Run covered %0d words over %0d mode and debounce settings, %0d pulses counted",
               words_sent, PHASE_COUNT + 2, pulses_seen);
      if (failures == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
